// ===== design/lph_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants of the linear probing hash table.
// -----------------------------------------------------------------------------
package lph_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int KEY_BYTES   = 8;
	localparam int VALUE_BITS  = 32;

	localparam int KEY_W   = 64;
	localparam int KLEN_W  = 4;
	localparam int SLOT_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int SIZE_W  = 9;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 2;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_SET    = 2'd1,
		OP_DELETE = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_INSERTED    = 3'd0,
		ST_OVERWRITTEN = 3'd1,
		ST_FOUND       = 3'd2,
		ST_NOT_FOUND   = 3'd3,
		ST_FULL        = 3'd4
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MULT   = 2'd0,
		REG_MOD    = 2'd1,
		REG_SIZE   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [KEY_W-1:0]  key;
		logic [KLEN_W-1:0] key_length;
		logic [31:0]       value_in;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [31:0]       value_out;
		logic [SLOT_W-1:0] slot_index;
		logic [CNT_W-1:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic [KLEN_W-1:0]     klen;
		logic [SLOT_W-1:0]     home;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

	function automatic logic [KEY_W-1:0] key_mask(input logic [KLEN_W-1:0] len);
		logic [KEY_W-1:0] m;
		m = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (KLEN_W'(i) < len) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

// ===== design/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash map with linear probing, one request at a time.
// -----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the single result is shown on rsp for one cycle with done high. The
// receiver cannot stall. One shared remainder unit does all reduction at one
// quotient bit per cycle. Each key byte takes a multiply step and, unless the
// modulus is zero, a remainder of the 64-bit product; the hash is then reduced
// by the table size to the home slot. Each occupied slot probed is read, then
// compared; the probe stops at an empty slot or once every slot is probed. A
// delete then scans its cluster to its end, shifting entries back, then replies.
// A write of table_size empties the table.
// -----------------------------------------------------------------------------
module linear_probe_hash_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lph_pkg::IDX_W-1:0] cfg_index,
	input  logic [lph_pkg::CFG_W-1:0] cfg_data,
	input  logic                      start,
	input  lph_pkg::req_t             req,
	output logic                      busy,
	output logic                      done,
	output lph_pkg::rsp_t             rsp
);

	localparam int SW = lph_pkg::SLOT_W;
	localparam int CW = lph_pkg::CNT_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL   = 8'b0000_0010,
		S_DIV   = 8'b0000_0100,
		S_PROBE = 8'b0000_1000,
		S_MATCH = 8'b0001_0000,
		S_SCAN  = 8'b0010_0000,
		S_SHIFT = 8'b0100_0000,
		S_REPLY = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [31:0]                   mult_q, mod_q;
	logic [lph_pkg::SIZE_W-1:0]    size_q;
	logic [lph_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [CW-1:0]                 count_q;

	logic [1:0]                    op_q;
	logic [lph_pkg::KEY_W-1:0]     key_q, kshift_q;
	logic [lph_pkg::KLEN_W-1:0]    klen_q, left_q;
	logic [lph_pkg::VALUE_BITS-1:0] val_q;

	logic [31:0]                   h_q, rem_q;
	logic [63:0]                   div_q;
	logic [6:0]                    step_q;
	logic                          home_mode_q;
	logic [SW-1:0]                 home_q, s_q, gap_q, j_q;
	logic [CW-1:0]                 n_q;
	lph_pkg::rsp_t                 res_q;

	lph_pkg::entry_t               mem [lph_pkg::TABLE_DEPTH];
	lph_pkg::entry_t               rdata_q, wdata;
	logic                          mem_we, mem_re;
	logic [SW-1:0]                 waddr, raddr;

	logic [CW-1:0]                 sz;
	logic [63:0]                   prod;
	logic [31:0]                   dvs, rem_nxt, home_src;
	logic [32:0]                   t, diff;
	logic                          ge;
	logic [SW-1:0]                 s_next, j_next;
	logic                          hit, stays;
	logic [lph_pkg::KLEN_W-1:0]    len_sat;

	always_comb begin
		if (size_q < lph_pkg::SIZE_W'(2)) begin
			sz = CW'(2);
		end else if (32'(size_q) > 32'(lph_pkg::TABLE_DEPTH)) begin
			sz = CW'(lph_pkg::TABLE_DEPTH);
		end else begin
			sz = CW'(size_q);
		end
	end

	assign len_sat = (req.key_length > lph_pkg::KLEN_W'(lph_pkg::KEY_BYTES))
		? lph_pkg::KLEN_W'(lph_pkg::KEY_BYTES) : req.key_length;

	assign prod = 64'(h_q) * 64'(mult_q) + 64'(kshift_q[7:0]);

	assign dvs     = home_mode_q ? 32'(sz) : mod_q;
	assign t       = {rem_q, div_q[63]};
	assign diff    = t - {1'b0, dvs};
	assign ge      = t >= {1'b0, dvs};
	assign rem_nxt = ge ? diff[31:0] : t[31:0];

	assign home_src = (state_q == S_MUL) ? prod[31:0] : rem_nxt;

	assign s_next = ((CW'(s_q) + CW'(1)) >= sz) ? '0 : s_q + SW'(1);
	assign j_next = ((CW'(j_q) + CW'(1)) >= sz) ? '0 : j_q + SW'(1);

	assign hit = (rdata_q.klen == klen_q) && (rdata_q.key == key_q);

	always_comb begin
		if (gap_q <= j_q) begin
			stays = (gap_q < rdata_q.home) && (rdata_q.home <= j_q);
		end else begin
			stays = (rdata_q.home > gap_q) || (rdata_q.home <= j_q);
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr  = s_q;
		raddr  = s_q;
		wdata  = '{key: key_q, klen: klen_q, home: home_q, value: val_q};
		unique case (state_q)
			S_PROBE: begin
				if (CW'(n_q) != sz) begin
					if (!valid_q[s_q]) begin
						mem_we = op_q == lph_pkg::OP_SET;
					end else begin
						mem_re = 1'b1;
					end
				end
			end
			S_MATCH: begin
				if (hit && op_q == lph_pkg::OP_SET) begin
					mem_we = 1'b1;
					wdata  = '{key: rdata_q.key, klen: rdata_q.klen,
						home: rdata_q.home, value: val_q};
				end
			end
			S_SCAN: begin
				raddr  = j_next;
				mem_re = (n_q != sz) && valid_q[j_next];
			end
			S_SHIFT: begin
				waddr  = gap_q;
				wdata  = rdata_q;
				mem_we = !stays;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mult_q      <= 32'd31;
			mod_q       <= 32'd1000000007;
			size_q      <= lph_pkg::SIZE_W'(256);
			valid_q     <= '0;
			count_q     <= '0;
			home_mode_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lph_pkg::REG_MULT: mult_q <= cfg_data;
					lph_pkg::REG_MOD:  mod_q  <= cfg_data;
					lph_pkg::REG_SIZE: begin
						size_q  <= cfg_data[lph_pkg::SIZE_W-1:0];
						valid_q <= '0;
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= req.opcode;
						key_q    <= req.key & lph_pkg::key_mask(len_sat);
						kshift_q <= req.key & lph_pkg::key_mask(len_sat);
						klen_q   <= len_sat;
						left_q   <= len_sat;
						val_q    <= req.value_in[lph_pkg::VALUE_BITS-1:0];
						h_q      <= '0;
						res_q    <= '{status: lph_pkg::ST_NOT_FOUND, value_out: '0,
							slot_index: '0, entry_count: count_q};
						if (req.opcode != lph_pkg::OP_LOOKUP &&
							req.opcode != lph_pkg::OP_SET &&
							req.opcode != lph_pkg::OP_DELETE) begin
							state_q <= S_REPLY;
						end else if (len_sat == '0) begin
							div_q       <= '0;
							rem_q       <= '0;
							step_q      <= 7'd32;
							home_mode_q <= 1'b1;
							state_q     <= S_DIV;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					kshift_q <= kshift_q >> 8;
					left_q   <= left_q - lph_pkg::KLEN_W'(1);
					rem_q    <= '0;
					if (mod_q == '0) begin
						h_q <= prod[31:0];
						if (left_q == lph_pkg::KLEN_W'(1)) begin
							div_q       <= {home_src, 32'd0};
							step_q      <= 7'd32;
							home_mode_q <= 1'b1;
							state_q     <= S_DIV;
						end
					end else begin
						div_q       <= prod;
						step_q      <= 7'd64;
						home_mode_q <= 1'b0;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					div_q  <= div_q << 1;
					rem_q  <= rem_nxt;
					step_q <= step_q - 7'd1;
					if (step_q == 7'd1) begin
						if (home_mode_q) begin
							home_q  <= rem_nxt[SW-1:0];
							s_q     <= rem_nxt[SW-1:0];
							n_q     <= '0;
							state_q <= S_PROBE;
						end else begin
							h_q <= rem_nxt;
							if (left_q == '0) begin
								div_q       <= {home_src, 32'd0};
								rem_q       <= '0;
								step_q      <= 7'd32;
								home_mode_q <= 1'b1;
							end else begin
								state_q <= S_MUL;
							end
						end
					end
				end
				S_PROBE: begin
					if (n_q == sz) begin
						if (op_q == lph_pkg::OP_SET) begin
							res_q.status <= lph_pkg::ST_FULL;
						end
						state_q <= S_REPLY;
					end else if (!valid_q[s_q]) begin
						if (op_q == lph_pkg::OP_SET) begin
							valid_q[s_q]      <= 1'b1;
							count_q           <= count_q + CW'(1);
							res_q.status      <= lph_pkg::ST_INSERTED;
							res_q.slot_index  <= s_q;
							res_q.entry_count <= count_q + CW'(1);
						end
						state_q <= S_REPLY;
					end else begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					if (hit) begin
						res_q.slot_index <= s_q;
						state_q          <= S_REPLY;
						case (op_q)
							lph_pkg::OP_LOOKUP: begin
								res_q.status    <= lph_pkg::ST_FOUND;
								res_q.value_out <= 32'(rdata_q.value);
							end
							lph_pkg::OP_SET: begin
								res_q.status <= lph_pkg::ST_OVERWRITTEN;
							end
							default: begin
								res_q.status      <= lph_pkg::ST_FOUND;
								valid_q[s_q]      <= 1'b0;
								count_q           <= count_q - CW'(1);
								res_q.entry_count <= count_q - CW'(1);
								gap_q             <= s_q;
								j_q               <= s_q;
								n_q               <= '0;
								state_q           <= S_SCAN;
							end
						endcase
					end else begin
						s_q     <= s_next;
						n_q     <= n_q + CW'(1);
						state_q <= S_PROBE;
					end
				end
				S_SCAN: begin
					if (n_q == sz || !valid_q[j_next]) begin
						state_q <= S_REPLY;
					end else begin
						j_q     <= j_next;
						n_q     <= n_q + CW'(1);
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (!stays) begin
						valid_q[gap_q] <= 1'b1;
						valid_q[j_q]   <= 1'b0;
						gap_q          <= j_q;
					end
					state_q <= S_SCAN;
				end
				S_REPLY: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_REPLY;
	assign rsp  = res_q;

endmodule

// ===== design/lph_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lph_checker
// Port-level checks of the hash table request and result sequencing.
// -----------------------------------------------------------------------------
module lph_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input lph_pkg::rsp_t rsp
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown outside a transaction");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.status <= lph_pkg::ST_FULL &&
			32'(rsp.entry_count) <= 32'(lph_pkg::TABLE_DEPTH))
		else $error("result fields out of range");

endmodule

bind linear_probe_hash_table lph_checker u_lph_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
